// ----- sv/dhpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dhpi_pkg
// Types and constants shared by the DSP host port interface modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dhpi_pkg;

  typedef enum logic [2:0] {
    ACT_HOST_READ  = 3'd0,
    ACT_HOST_WRITE = 3'd1,
    ACT_DSP_READ   = 3'd2,
    ACT_DSP_WRITE  = 3'd3,
    ACT_TICK       = 3'd4
  } dhpi_action_e;

  typedef enum logic [2:0] {
    ADR_ICR    = 3'd0,
    ADR_CVR    = 3'd1,
    ADR_ISR    = 3'd2,
    ADR_IVR    = 3'd3,
    ADR_UNUSED = 3'd4,
    ADR_HIGH   = 3'd5,
    ADR_MID    = 3'd6,
    ADR_LOW    = 3'd7
  } dhpi_addr_e;

  localparam int unsigned IsrRxdf = 0;
  localparam int unsigned IsrTxde = 1;
  localparam int unsigned IsrTrdy = 2;
  localparam int unsigned IsrHreq = 7;

  localparam int unsigned HsrHrdf = 0;
  localparam int unsigned HsrHtde = 1;
  localparam int unsigned HsrHcp  = 2;
  localparam int unsigned HsrHf0  = 3;
  localparam int unsigned HsrHf1  = 4;

  localparam logic [7:0] IcrWriteMask = 8'hfb;
  localparam logic [7:0] CvrWriteMask = 8'h9f;
  localparam logic [7:0] CvrReset     = 8'h12;
  localparam logic [7:0] IvrReset     = 8'h0f;
  localparam logic [7:0] IsrReset     = 8'h06;
  localparam logic [7:0] HsrReset     = 8'h02;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  address;
    logic [7:0]  write_byte;
    logic [23:0] dsp_word;
  } dhpi_item_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [7:0]  dsp_status;
    logic [7:0]  host_status;
    logic [23:0] receive_word;
    logic        boot_valid;
    logic [8:0]  boot_address;
    logic [23:0] boot_data;
    logic        is_running;
  } dhpi_result_t;

endpackage

`default_nettype wire

// ----- sv/dsp_host_port_interface.sv -----
// A beat accepted at the input goes to the input register, then to the result register at the output.
// Throughput: one beat per cycle while out_ready_i does not stall the result register.
// The next beat sees the state left by the previous one with no extra wait.
// Reset restores all host and DSP side registers and clears both stages.
// ----------------------------------------------------------------------------
// dsp_host_port_interface
// DSP host port with bootstrap loader, input register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_host_port_interface #(
  parameter int unsigned BOOT_WORDS = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [2:0]  address_i,
  input  wire logic [7:0]  write_byte_i,
  input  wire logic [23:0] dsp_word_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  read_byte_o,
  output      logic [7:0]  dsp_status_o,
  output      logic [7:0]  host_status_o,
  output      logic [23:0] receive_word_o,
  output      logic        boot_valid_o,
  output      logic [8:0]  boot_address_o,
  output      logic [23:0] boot_data_o,
  output      logic        is_running_o
);
  import dhpi_pkg::*;

  logic         in_v_q;
  dhpi_item_t   item_q;
  logic         out_v_q;
  dhpi_result_t res_q;
  dhpi_result_t res_d;
  logic         adv;

  assign adv        = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.action     <= action_i;
      item_q.address    <= address_i;
      item_q.write_byte <= write_byte_i;
      item_q.dsp_word   <= dsp_word_i;
    end
  end

  dhpi_core #(
    .BOOT_WORDS(BOOT_WORDS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .item_i  (item_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign read_byte_o    = res_q.read_byte;
  assign dsp_status_o   = res_q.dsp_status;
  assign host_status_o  = res_q.host_status;
  assign receive_word_o = res_q.receive_word;
  assign boot_valid_o   = res_q.boot_valid;
  assign boot_address_o = res_q.boot_address;
  assign boot_data_o    = res_q.boot_data;
  assign is_running_o   = res_q.is_running;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |-> !adv)
    else $error("result register overwritten while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !adv) |=> in_v_q)
    else $error("input beat lost while waiting");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_v_q)
    else $error("processed beat did not reach the output");
`endif

endmodule

`default_nettype wire

// ----- sv/dhpi_core.sv -----
// ----------------------------------------------------------------------------
// dhpi_core
// Host port register file and the combinational update for one beat, stored on step_i.
// ----------------------------------------------------------------------------
`default_nettype none

module dhpi_core #(
  parameter int unsigned BOOT_WORDS = 512
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire dhpi_pkg::dhpi_item_t   item_i,
  output      dhpi_pkg::dhpi_result_t result_o
);
  import dhpi_pkg::*;

  logic [7:0]  icr_q, icr_d, cvr_q, cvr_d, isr_q, isr_d, ivr_q, ivr_d;
  logic [7:0]  tx0_q, tx0_d, tx1_q, tx1_d, tx2_q, tx2_d;
  logic [7:0]  rx0_q, rx0_d, rx1_q, rx1_d, rx2_q, rx2_d;
  logic [7:0]  hsr_q, hsr_d;
  logic [23:0] rxw_q, rxw_d, txw_q, txw_d;
  logic [9:0]  pos_q, pos_d;
  logic        run_q, run_d;
  logic [7:0]  rbyte;
  logic        bvalid;
  logic [8:0]  baddr;
  logic [23:0] bdata;
  dhpi_action_e act;
  dhpi_addr_e   adr;

  assign act = dhpi_action_e'(item_i.action);
  assign adr = dhpi_addr_e'(item_i.address);

  always_comb begin
    icr_d = icr_q;
    cvr_d = cvr_q;
    isr_d = isr_q;
    ivr_d = ivr_q;
    tx0_d = tx0_q;
    tx1_d = tx1_q;
    tx2_d = tx2_q;
    rx0_d = rx0_q;
    rx1_d = rx1_q;
    rx2_d = rx2_q;
    hsr_d = hsr_q;
    rxw_d = rxw_q;
    txw_d = txw_q;
    pos_d = pos_q;
    run_d = run_q;
    rbyte = 8'd0;
    bvalid = 1'b0;
    baddr = 9'd0;
    bdata = 24'd0;
    unique case (act)
      ACT_HOST_READ: begin
        unique case (adr)
          ADR_ICR:    rbyte = icr_q;
          ADR_CVR:    rbyte = cvr_q;
          ADR_ISR:    rbyte = isr_q;
          ADR_IVR:    rbyte = ivr_q;
          ADR_UNUSED: rbyte = 8'd0;
          ADR_HIGH:   rbyte = rx0_q;
          ADR_MID:    rbyte = rx1_q;
          ADR_LOW: begin
            rbyte = rx2_q;
            isr_d[IsrRxdf] = 1'b0;
          end
        endcase
      end
      ACT_HOST_WRITE: begin
        unique case (adr)
          ADR_ICR: begin
            icr_d = item_i.write_byte & IcrWriteMask;
            hsr_d[HsrHf0] = item_i.write_byte[HsrHf0];
            hsr_d[HsrHf1] = item_i.write_byte[HsrHf1];
          end
          ADR_CVR: begin
            cvr_d = item_i.write_byte & CvrWriteMask;
            hsr_d[HsrHcp] = item_i.write_byte[7];
          end
          ADR_ISR, ADR_UNUSED: ;
          ADR_IVR:  ivr_d = item_i.write_byte;
          ADR_HIGH: tx0_d = item_i.write_byte;
          ADR_MID:  tx1_d = item_i.write_byte;
          ADR_LOW: begin
            tx2_d = item_i.write_byte;
            if (!run_q) begin
              bvalid = 1'b1;
              baddr = pos_q[8:0];
              bdata = {tx0_q, tx1_q, item_i.write_byte};
              if (({1'b0, pos_q} + 11'd1) == 11'(BOOT_WORDS)) begin
                run_d = 1'b1;
              end
              pos_d = pos_q + 10'd1;
            end else begin
              if (isr_q[IsrTrdy]) begin
                rxw_d = {tx0_q, tx1_q, item_i.write_byte};
                hsr_d[HsrHrdf] = 1'b1;
              end else begin
                isr_d[IsrTxde] = 1'b0;
              end
              isr_d[IsrTrdy] = isr_d[IsrTxde] && !hsr_d[HsrHrdf];
            end
          end
        endcase
      end
      ACT_DSP_READ: begin
        hsr_d[HsrHrdf] = 1'b0;
        isr_d[IsrTrdy] = isr_q[IsrTxde];
      end
      ACT_DSP_WRITE: begin
        txw_d = item_i.dsp_word;
        hsr_d[HsrHtde] = 1'b0;
      end
      ACT_TICK: begin
        if (!isr_q[IsrTxde] && !hsr_q[HsrHrdf]) begin
          rxw_d = {tx0_q, tx1_q, tx2_q};
          hsr_d[HsrHrdf] = 1'b1;
          isr_d[IsrTxde] = 1'b1;
          isr_d[IsrTrdy] = 1'b0;
        end
        if (!isr_q[IsrRxdf] && !hsr_q[HsrHtde]) begin
          rx2_d = txw_q[7:0];
          rx1_d = txw_q[15:8];
          rx0_d = txw_q[23:16];
          hsr_d[HsrHtde] = 1'b1;
          isr_d[IsrRxdf] = 1'b1;
        end
        if (icr_q[6:5] == 2'b00) begin
          isr_d[IsrHreq] = |(icr_q[1:0] & isr_d[1:0]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icr_q <= 8'd0;
      cvr_q <= CvrReset;
      isr_q <= IsrReset;
      ivr_q <= IvrReset;
      tx0_q <= 8'd0;
      tx1_q <= 8'd0;
      tx2_q <= 8'd0;
      rx0_q <= 8'd0;
      rx1_q <= 8'd0;
      rx2_q <= 8'd0;
      hsr_q <= HsrReset;
      rxw_q <= 24'd0;
      txw_q <= 24'd0;
      pos_q <= 10'd0;
      run_q <= 1'b0;
    end else if (step_i) begin
      icr_q <= icr_d;
      cvr_q <= cvr_d;
      isr_q <= isr_d;
      ivr_q <= ivr_d;
      tx0_q <= tx0_d;
      tx1_q <= tx1_d;
      tx2_q <= tx2_d;
      rx0_q <= rx0_d;
      rx1_q <= rx1_d;
      rx2_q <= rx2_d;
      hsr_q <= hsr_d;
      rxw_q <= rxw_d;
      txw_q <= txw_d;
      pos_q <= pos_d;
      run_q <= run_d;
    end
  end

  always_comb begin
    result_o.read_byte    = rbyte;
    result_o.dsp_status   = hsr_d;
    result_o.host_status  = isr_d;
    result_o.receive_word = rxw_d;
    result_o.boot_valid   = bvalid;
    result_o.boot_address = baddr;
    result_o.boot_data    = bdata;
    result_o.is_running   = run_d;
  end

`ifndef NO_ASSERTIONS
  a_run_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |=> run_q)
    else $error("running flag dropped");

  a_trdy_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    isr_q[IsrTrdy] == (isr_q[IsrTxde] && !hsr_q[HsrHrdf]))
    else $error("TRDY differs from TXDE and not HRDF");

  a_boot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && bvalid) |=> (pos_q == $past(pos_q) + 10'd1))
    else $error("boot position did not advance on a boot word");

  a_boot_only_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid |-> !run_q)
    else $error("boot word stored while running");
`endif

endmodule

`default_nettype wire
